// File: rtl/cct_pkg.sv
package cct_pkg;

	// Fixed-point format of positions, durations, times and coefficients.
	localparam int FRAC_BITS = 16;
	localparam int MAX_KEYFRAMES = 16;

	localparam int POS_W = 32;
	localparam int DUR_W = 32;
	localparam int TIME_W = 32;
	localparam int COEF_W = 48;
	localparam int PER_W = 40;
	localparam int MUL_W = 32;

	// Widest dividend is a slope difference shifted by twice the fraction width.
	localparam int DIV_NUM_W = COEF_W + 2 * FRAC_BITS;
	localparam int DIV_DEN_W = 2 * DUR_W;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	localparam logic [COEF_W-2:0] COEF_MAX = '1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_READY = 2'd1,
		ST_FULL      = 2'd2,
		ST_ZERO_DUR  = 2'd3
	} status_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_B1_RD_I,
		S_B1_RD_N,
		S_B1_DIV,
		S_B1_WAIT,
		S_B2_RD_I,
		S_B2_RD_N,
		S_B2_START,
		S_B2_SQ,
		S_B2_CUB,
		S_Q_MOD,
		S_Q_SRCH,
		S_H_LO,
		S_H_HI,
		S_H_SUM,
		S_RESP
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] nbits;
	} div_req_t;

endpackage

// File: rtl/cct_div.sv
// Restoring divider, one quotient bit per cycle. The low nbits of num are
// divided by den; done pulses for one cycle when quo and rem are final.
module cct_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cct_pkg::div_req_t                   req,
	input  logic [cct_pkg::DIV_NUM_W-1:0]       num,
	input  logic [cct_pkg::DIV_DEN_W-1:0]       den,
	output logic                                done,
	output logic [cct_pkg::DIV_NUM_W-1:0]       quo,
	output logic [cct_pkg::DIV_DEN_W-1:0]       rem
);

	logic                             busy_q;
	logic                             done_q;
	logic [cct_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [cct_pkg::DIV_NUM_W-1:0]    num_q;
	logic [cct_pkg::DIV_NUM_W-1:0]    quo_q;
	logic [cct_pkg::DIV_DEN_W-1:0]    rem_q;
	logic [cct_pkg::DIV_DEN_W-1:0]    den_q;
	logic [cct_pkg::DIV_DEN_W:0]      trial;
	logic [cct_pkg::DIV_DEN_W:0]      diff;
	logic                             ge;

	assign trial = {rem_q, num_q[cct_pkg::DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == cct_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// Align the dividend so its top used bit is shifted in first.
			num_q <= num << (cct_pkg::DIV_CNT_W'(cct_pkg::DIV_NUM_W) - req.nbits);
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[cct_pkg::DIV_DEN_W-1:0] : trial[cct_pkg::DIV_DEN_W-1:0];
			quo_q <= {quo_q[cct_pkg::DIV_NUM_W-2:0], ge};
			num_q <= num_q << 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// File: rtl/cct_mul.sv
// Unsigned multiplier with a registered product.
module cct_mul (
	input  logic                          clk,
	input  logic [cct_pkg::MUL_W-1:0]     a,
	input  logic [cct_pkg::MUL_W-1:0]     b,
	output logic [2*cct_pkg::MUL_W-1:0]   p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// File: rtl/cyclic_cubic_trajectory.sv
// Channel | Direction | tdata (low bit up)                         | tuser      | tlast
// s_axis  | in        | key_position, key_duration, query_time     | operation  | last_keyframe
// m_axis  | out       | value                                      | status     | -
//
// One item is taken at a time; s_axis_tready is high only while the sequencer is idle.
// A load only stores its keyframe; the load that closes the set then builds the curve
// on the bit-serial divider, with one slope division and two coefficient divisions per segment.
// A query wraps the time into the period on the divider, searches the segments one at
// a time and runs three Horner rounds, each a low-part and a high-part product on the
// shared 32x32 multiplier and a sum.
// Reset clears the keyframe count, period and curve-ready flag; the tables need no clearing.
// A finished result waits in the output register while m_axis_tready is low.
module cyclic_cubic_trajectory #(
	parameter int MAX_KEYFRAMES = cct_pkg::MAX_KEYFRAMES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // key_position[31:0], key_duration[63:32], query_time[95:64]
	input  logic [0:0]  s_axis_tuser,  // operation
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // value
	output logic [1:0]  m_axis_tuser   // status
);

	localparam int AW = $clog2(MAX_KEYFRAMES);
	localparam int CW = $clog2(MAX_KEYFRAMES + 1);
	localparam int CF = cct_pkg::COEF_W;
	localparam int FB = cct_pkg::FRAC_BITS;
	localparam int NW = cct_pkg::DIV_NUM_W;
	localparam int DW = cct_pkg::DIV_DEN_W;
	localparam int PW = cct_pkg::PER_W;
	localparam int KW = cct_pkg::DIV_CNT_W;

	// Saturate a widened coefficient sum to the symmetric coefficient range.
	function automatic logic [CF-1:0] sat_coef(input logic signed [CF:0] s);
		logic signed [CF:0] lim;
		logic signed [CF:0] nlim;
		lim  = $signed({2'b00, cct_pkg::COEF_MAX});
		nlim = -lim;
		if (s > lim) sat_coef = lim[CF-1:0];
		else if (s < nlim) sat_coef = nlim[CF-1:0];
		else sat_coef = s[CF-1:0];
	endfunction

	// Clamp an unsigned quotient magnitude to the largest coefficient.
	function automatic logic [CF-2:0] sat_mag(input logic [NW-1:0] q);
		sat_mag = (|q[NW-1:CF-1]) ? cct_pkg::COEF_MAX : q[CF-2:0];
	endfunction

	function automatic logic [CF-1:0] apply_sign(input logic neg, input logic [CF-2:0] mag);
		apply_sign = neg ? (CF'(0) - {1'b0, mag}) : {1'b0, mag};
	endfunction

	// Keyframe and coefficient tables.
	logic [cct_pkg::POS_W-1:0] pos_mem   [MAX_KEYFRAMES];
	logic [cct_pkg::DUR_W-1:0] dur_mem   [MAX_KEYFRAMES];
	logic [CF-1:0]             lin_mem   [MAX_KEYFRAMES];
	logic [CF-1:0]             sq_mem    [MAX_KEYFRAMES];
	logic [CF-1:0]             cub_mem   [MAX_KEYFRAMES];
	logic [PW-1:0]             start_mem [MAX_KEYFRAMES];

	logic [cct_pkg::POS_W-1:0] rd_pos;
	logic [cct_pkg::DUR_W-1:0] rd_dur;
	logic [CF-1:0]             rd_lin;
	logic [CF-1:0]             rd_sq;
	logic [CF-1:0]             rd_cub;
	logic [PW-1:0]             rd_start;

	cct_pkg::state_t state_q, state_d;

	// Accepted item.
	cct_pkg::op_t              op_q;
	logic [cct_pkg::POS_W-1:0] pos_in_q;
	logic [cct_pkg::DUR_W-1:0] dur_in_q;
	logic                      last_in_q;
	logic [cct_pkg::TIME_W-1:0] time_q;

	// Curve state.
	logic [CW-1:0] count_q;
	logic [PW-1:0] period_q;
	logic          ready_q;

	// Sequencer working registers.
	logic [CW-1:0]             n_q;
	logic [AW-1:0]             i_q;
	logic [cct_pkg::POS_W-1:0] pos_i_q;
	logic [cct_pkg::DUR_W-1:0] dur_i_q;
	logic                      rise_neg_q;
	logic [CF-1:0]             lin_i_q;
	logic [CF:0]               e_q;
	logic [PW-1:0]             acc_q;
	logic [PW-1:0]             r_q;
	logic [cct_pkg::MUL_W-1:0] u_q;
	logic [CF-1:0]             h_q;
	logic [CF-1:0]             sq_q;
	logic [CF-1:0]             lin_q;
	logic [cct_pkg::POS_W-1:0] pos_q;
	logic [2*cct_pkg::MUL_W-1:0] lo_q;
	logic [1:0]                rnd_q;
	logic [31:0]               value_q;
	cct_pkg::status_t          status_q;

	logic        m_valid_q;
	logic [31:0] m_data_q;
	logic [1:0]  m_user_q;

	// Shared units.
	cct_pkg::div_req_t           div_req;
	logic [NW-1:0]               div_num;
	logic [DW-1:0]               div_den;
	logic                        div_done;
	logic [NW-1:0]               div_quo;
	logic [DW-1:0]               div_rem;
	logic [cct_pkg::MUL_W-1:0]   mul_a;
	logic [cct_pkg::MUL_W-1:0]   mul_b;
	logic [2*cct_pkg::MUL_W-1:0] mul_p;

	// Table control.
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic          we_key;
	logic          we_lin;
	logic          we_sq;
	logic          we_cub;
	logic [CF-1:0] wdata_coef;

	// Combinational datapath terms.
	logic [CW-1:0]  cnt_eff;
	logic           last_i;
	logic [AW-1:0]  nx;
	logic [32:0]    rise;
	logic [32:0]    rise_mag;
	logic [CF:0]    e_new;
	logic [CF:0]    e_mag_w;
	logic [CF-1:0]  e_mag;
	logic           t_neg;
	logic [31:0]    t_mag;
	logic [PW-1:0]  m_rem;
	logic [PW-1:0]  r_new;
	logic [PW:0]    seg_end;
	logic           hit;
	logic [PW-1:0]  u_full;
	logic           h_neg;
	logic [CF-1:0]  h_mag_w;
	logic [CF-2:0]  h_mag;
	logic [NW-1:0]  prod_full;
	logic [NW-FB-1:0] prod_sh;
	logic [CF-2:0]  prod_mag;
	logic [CF-1:0]  prod_s;
	logic [CF:0]    sum_w;
	logic signed [CF:0] sum_s;
	logic [31:0]    value_sat;

	cct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	cct_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// A load after a finished curve starts a fresh set.
	assign cnt_eff = ready_q ? '0 : count_q;
	assign last_i  = ((CW'(i_q) + 1'b1) == n_q);
	assign nx      = last_i ? '0 : AW'(i_q + 1'b1);

	// Rise of the segment from keyframe i to its successor.
	assign rise     = {rd_pos[31], rd_pos} - {pos_i_q[31], pos_i_q};
	assign rise_mag = rise[32] ? (33'd0 - rise) : rise;

	// Slope difference across a segment; it always fits in 48 bits of magnitude.
	assign e_new   = {rd_lin[CF-1], rd_lin} - {lin_i_q[CF-1], lin_i_q};
	assign e_mag_w = e_q[CF] ? ((CF + 1)'(0) - e_q) : e_q;
	assign e_mag   = e_mag_w[CF-1:0];

	// Floor wrap of the query time into the period.
	assign t_neg = time_q[31];
	assign t_mag = t_neg ? (32'd0 - time_q) : time_q;
	assign m_rem = div_rem[PW-1:0];
	assign r_new = (t_neg && (m_rem != '0)) ? (period_q - m_rem) : m_rem;

	// A time on a boundary belongs to the earlier segment.
	assign seg_end = {1'b0, rd_start} + PW'(rd_dur);
	assign hit     = ({1'b0, r_q} <= seg_end) || ((CW'(i_q) + 1'b1) == count_q);
	assign u_full  = r_q - rd_start;

	// Horner step: magnitude product split into a low 32-bit and a high 15-bit part, shifted and clamped.
	assign h_neg     = h_q[CF-1];
	assign h_mag_w   = h_neg ? (CF'(0) - h_q) : h_q;
	assign h_mag     = h_mag_w[CF-2:0];
	assign prod_full = {mul_p[NW-33:0], 32'd0} + NW'(lo_q);
	assign prod_sh   = prod_full[NW-1:FB];
	assign prod_mag  = (|prod_sh[NW-FB-1:CF-1]) ? cct_pkg::COEF_MAX : prod_sh[CF-2:0];
	assign prod_s    = apply_sign(h_neg, prod_mag);

	always_comb begin
		sum_w = {prod_s[CF-1], prod_s} + {sq_q[CF-1], sq_q};
		if (rnd_q == 2'd1) sum_w = {prod_s[CF-1], prod_s} + {lin_q[CF-1], lin_q};
		else if (rnd_q == 2'd2)
			sum_w = {prod_s[CF-1], prod_s} + {{(CF-31){pos_q[31]}}, pos_q};
	end
	assign sum_s = $signed(sum_w);

	always_comb begin
		if (sum_s > $signed((CF + 1)'(32'h7FFF_FFFF))) value_sat = 32'h7FFF_FFFF;
		else if (sum_s < -$signed((CF + 1)'(33'h0_8000_0000))) value_sat = 32'h8000_0000;
		else value_sat = sum_w[31:0];
	end

	// Sequencer: next state and unit controls.
	always_comb begin
		state_d       = state_q;
		raddr         = '0;
		waddr         = i_q;
		we_key        = 1'b0;
		we_lin        = 1'b0;
		we_sq         = 1'b0;
		we_cub        = 1'b0;
		wdata_coef    = apply_sign(rise_neg_q, sat_mag(div_quo));
		div_req.start = 1'b0;
		div_req.nbits = KW'(NW);
		div_num       = '0;
		div_den       = DW'(dur_i_q);
		mul_a         = dur_i_q;
		mul_b         = dur_i_q;
		s_axis_tready = 1'b0;

		unique case (state_q)
			cct_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_d = cct_pkg::S_DECODE;
			end
			cct_pkg::S_DECODE: begin
				if (op_q == cct_pkg::OP_LOAD) begin
					if (dur_in_q == '0) begin
						state_d = cct_pkg::S_RESP;
					end else if (cnt_eff >= CW'(MAX_KEYFRAMES)) begin
						state_d = cct_pkg::S_RESP;
					end else begin
						waddr  = cnt_eff[AW-1:0];
						we_key = 1'b1;
						state_d = last_in_q ? cct_pkg::S_B1_RD_I : cct_pkg::S_RESP;
					end
				end else if (!ready_q || count_q == '0 || period_q == '0) begin
					state_d = cct_pkg::S_RESP;
				end else begin
					div_req.start = 1'b1;
					div_req.nbits = KW'(32);
					div_num       = NW'(t_mag);
					div_den       = DW'(period_q);
					state_d       = cct_pkg::S_Q_MOD;
				end
			end
			cct_pkg::S_B1_RD_I: begin
				raddr   = i_q;
				state_d = cct_pkg::S_B1_RD_N;
			end
			cct_pkg::S_B1_RD_N: begin
				raddr   = nx;
				state_d = cct_pkg::S_B1_DIV;
			end
			cct_pkg::S_B1_DIV: begin
				div_req.start = 1'b1;
				div_req.nbits = KW'(33 + FB);
				div_num       = NW'(rise_mag) << FB;
				state_d       = cct_pkg::S_B1_WAIT;
			end
			cct_pkg::S_B1_WAIT: begin
				if (div_done) begin
					waddr   = nx;
					we_lin  = 1'b1;
					state_d = last_i ? cct_pkg::S_B2_RD_I : cct_pkg::S_B1_RD_I;
				end
			end
			cct_pkg::S_B2_RD_I: begin
				raddr   = i_q;
				state_d = cct_pkg::S_B2_RD_N;
			end
			cct_pkg::S_B2_RD_N: begin
				raddr   = nx;
				state_d = cct_pkg::S_B2_START;
			end
			cct_pkg::S_B2_START: begin
				div_req.start = 1'b1;
				div_req.nbits = KW'(CF + FB + 1);
				div_num       = NW'(e_new[CF] ? ((CF + 1)'(0) - e_new) : e_new) << (FB + 1);
				state_d       = cct_pkg::S_B2_SQ;
			end
			cct_pkg::S_B2_SQ: begin
				if (div_done) begin
					wdata_coef    = apply_sign(e_q[CF], sat_mag(div_quo));
					we_sq         = 1'b1;
					div_req.start = 1'b1;
					div_req.nbits = KW'(NW);
					div_num       = NW'(e_mag) << (2 * FB);
					div_den       = mul_p;
					state_d       = cct_pkg::S_B2_CUB;
				end
			end
			cct_pkg::S_B2_CUB: begin
				if (div_done) begin
					wdata_coef = apply_sign(!e_q[CF], sat_mag(div_quo));
					we_cub     = 1'b1;
					state_d    = last_i ? cct_pkg::S_RESP : cct_pkg::S_B2_RD_I;
				end
			end
			cct_pkg::S_Q_MOD: begin
				if (div_done) begin
					raddr   = '0;
					state_d = cct_pkg::S_Q_SRCH;
				end
			end
			cct_pkg::S_Q_SRCH: begin
				if (hit) begin
					state_d = cct_pkg::S_H_LO;
				end else begin
					raddr = AW'(i_q + 1'b1);
				end
			end
			cct_pkg::S_H_LO: begin
				mul_a   = h_mag[31:0];
				mul_b   = u_q;
				state_d = cct_pkg::S_H_HI;
			end
			cct_pkg::S_H_HI: begin
				mul_a   = cct_pkg::MUL_W'(h_mag[CF-2:32]);
				mul_b   = u_q;
				state_d = cct_pkg::S_H_SUM;
			end
			cct_pkg::S_H_SUM: begin
				state_d = (rnd_q == 2'd2) ? cct_pkg::S_RESP : cct_pkg::S_H_LO;
			end
			cct_pkg::S_RESP: begin
				if (!m_valid_q || m_axis_tready) state_d = cct_pkg::S_IDLE;
			end
			default: state_d = cct_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cct_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// Table ports: one write address, one read address shared by all tables, registered read data.
	always_ff @(posedge clk) begin
		if (we_key) begin
			pos_mem[waddr] <= pos_in_q;
			dur_mem[waddr] <= dur_in_q;
		end
		if (we_lin) lin_mem[waddr] <= wdata_coef;
		if (we_sq) sq_mem[waddr] <= wdata_coef;
		if (we_cub) begin
			cub_mem[waddr]   <= wdata_coef;
			start_mem[waddr] <= acc_q;
		end
		rd_pos   <= pos_mem[raddr];
		rd_dur   <= dur_mem[raddr];
		rd_lin   <= lin_mem[raddr];
		rd_sq    <= sq_mem[raddr];
		rd_cub   <= cub_mem[raddr];
		rd_start <= start_mem[raddr];
	end

	// Curve state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			period_q  <= '0;
			ready_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == cct_pkg::S_DECODE && op_q == cct_pkg::OP_LOAD && dur_in_q != '0) begin
				ready_q <= 1'b0;
				if (ready_q) period_q <= '0;
				if (cnt_eff >= CW'(MAX_KEYFRAMES)) count_q <= '0;
				else count_q <= cnt_eff + 1'b1;
			end
			if (state_q == cct_pkg::S_B2_CUB && div_done && last_i) begin
				period_q <= acc_q + PW'(dur_i_q);
				ready_q  <= 1'b1;
			end
			if (state_q == cct_pkg::S_RESP && (!m_valid_q || m_axis_tready)) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			cct_pkg::S_IDLE: begin
				op_q      <= cct_pkg::op_t'(s_axis_tuser[0]);
				pos_in_q  <= s_axis_tdata[31:0];
				dur_in_q  <= s_axis_tdata[63:32];
				time_q    <= s_axis_tdata[95:64];
				last_in_q <= s_axis_tlast;
				value_q   <= '0;
				status_q  <= cct_pkg::ST_OK;
			end
			cct_pkg::S_DECODE: begin
				i_q   <= '0;
				acc_q <= '0;
				n_q   <= cnt_eff + 1'b1;
				if (op_q == cct_pkg::OP_LOAD) begin
					if (dur_in_q == '0) status_q <= cct_pkg::ST_ZERO_DUR;
					else if (cnt_eff >= CW'(MAX_KEYFRAMES)) status_q <= cct_pkg::ST_FULL;
				end else if (!ready_q || count_q == '0 || period_q == '0) begin
					status_q <= cct_pkg::ST_NOT_READY;
				end
			end
			cct_pkg::S_B1_RD_N: begin
				pos_i_q <= rd_pos;
				dur_i_q <= rd_dur;
			end
			cct_pkg::S_B1_DIV: rise_neg_q <= rise[32];
			cct_pkg::S_B1_WAIT: begin
				if (div_done) i_q <= last_i ? '0 : AW'(i_q + 1'b1);
			end
			cct_pkg::S_B2_RD_N: begin
				lin_i_q <= rd_lin;
				dur_i_q <= rd_dur;
			end
			cct_pkg::S_B2_START: e_q <= e_new;
			cct_pkg::S_B2_CUB: begin
				if (div_done) begin
					acc_q <= acc_q + PW'(dur_i_q);
					i_q   <= AW'(i_q + 1'b1);
				end
			end
			cct_pkg::S_Q_MOD: begin
				if (div_done) begin
					r_q <= r_new;
					i_q <= '0;
				end
			end
			cct_pkg::S_Q_SRCH: begin
				if (hit) begin
					u_q   <= (|u_full[PW-1:32]) ? 32'hFFFF_FFFF : u_full[31:0];
					h_q   <= rd_cub;
					sq_q  <= rd_sq;
					lin_q <= rd_lin;
					pos_q <= rd_pos;
					rnd_q <= 2'd0;
				end else begin
					i_q <= AW'(i_q + 1'b1);
				end
			end
			cct_pkg::S_H_HI: lo_q <= mul_p;
			cct_pkg::S_H_SUM: begin
				if (rnd_q == 2'd2) value_q <= value_sat;
				else h_q <= sat_coef(sum_s);
				rnd_q <= rnd_q + 1'b1;
			end
			cct_pkg::S_RESP: begin
				if (!m_valid_q || m_axis_tready) begin
					m_data_q <= value_q;
					m_user_q <= status_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

// File: tb/sv/cyclic_cubic_trajectory_tb.sv
module cyclic_cubic_trajectory_tb;

	// One input item as the sender sees it, before packing onto the bus.
	typedef struct {
		cct_pkg::op_t       op;
		logic signed [31:0] position;
		logic [31:0]        duration;
		bit                 closes_set;
		logic signed [31:0] qtime;
	} servo_cmd_t;

	// One result item: trajectory value and status code.
	typedef struct {
		logic [31:0]      value;
		cct_pkg::status_t status;
	} servo_resp_t;

	// A row of the directed table. When typed is set, the response is written out
	// by hand; otherwise the trajectory predictor supplies it.
	typedef struct {
		servo_cmd_t  cmd;
		bit          typed;
		servo_resp_t resp;
	} directed_row_t;

	localparam longint SAT_LIMIT = 64'sh7FFF_FFFF_FFFF;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	cyclic_cubic_trajectory u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// Predictor copy of the keyframe table and the built curve.
	longint      kf_pos[cct_pkg::MAX_KEYFRAMES];
	bit [31:0]   kf_dur[cct_pkg::MAX_KEYFRAMES];
	longint      cf_lin[cct_pkg::MAX_KEYFRAMES];
	longint      cf_sq[cct_pkg::MAX_KEYFRAMES];
	longint      cf_cub[cct_pkg::MAX_KEYFRAMES];
	bit [63:0]   seg_begin[cct_pkg::MAX_KEYFRAMES];
	int          kf_count;
	bit [63:0]   period_len;
	bit          curve_built;

	servo_resp_t pending_resp[$];
	bit          failed;
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("cyclic_cubic_trajectory test failed");
		$finish;
	end

	function automatic longint clip48(longint v);
		if (v > SAT_LIMIT) return SAT_LIMIT;
		if (v < -SAT_LIMIT) return -SAT_LIMIT;
		return v;
	endfunction

	// Restoring division of x * 2^k by d, truncated, clipped to the coefficient limit.
	function automatic bit [63:0] scaled_quotient(bit [63:0] x, int k, bit [63:0] d);
		bit [63:0] q;
		bit [63:0] r;
		q = x / d;
		r = x % d;
		if (q > SAT_LIMIT) return SAT_LIMIT;
		for (int i = 0; i < k; i++) begin
			if (r >= d - r) begin
				r = r - (d - r);
				q = 2 * q + 1;
			end else begin
				r = r << 1;
				q = 2 * q;
			end
			if (q > SAT_LIMIT) return SAT_LIMIT;
		end
		return q;
	endfunction

	function automatic longint signed_scaled_quotient(longint v, int k, bit [63:0] d);
		bit [63:0] mag;
		longint    q;
		mag = (v < 0) ? -v : v;
		q = longint'(scaled_quotient(mag, k, d));
		return (v < 0) ? -q : q;
	endfunction

	// Fixed-point product with the fraction bits dropped toward zero.
	function automatic longint fx_mul(longint a, bit [63:0] u);
		bit [63:0] mag;
		bit [63:0] lo;
		bit [63:0] hi;
		bit [63:0] res;
		mag = (a < 0) ? -a : a;
		lo = (mag & 64'hFFFF_FFFF) * u;
		hi = (mag >> 32) * u;
		if ((hi >> (15 + cct_pkg::FRAC_BITS)) != 0) begin
			res = SAT_LIMIT;
		end else begin
			res = (hi << (32 - cct_pkg::FRAC_BITS)) + (lo >> cct_pkg::FRAC_BITS);
			if (res > SAT_LIMIT) res = SAT_LIMIT;
		end
		return (a < 0) ? -longint'(res) : longint'(res);
	endfunction

	// Slopes come from the segment that ends at each keyframe; the last segment
	// wraps back to keyframe zero.
	function automatic void build_trajectory();
		longint    slope[cct_pkg::MAX_KEYFRAMES];
		bit [63:0] acc;
		int        nx;
		longint    e;
		bit [63:0] d;
		acc = 0;
		for (int i = 0; i < kf_count; i++) begin
			nx = (i + 1 == kf_count) ? 0 : i + 1;
			slope[nx] = signed_scaled_quotient(kf_pos[nx] - kf_pos[i], cct_pkg::FRAC_BITS,
				64'(kf_dur[i]));
		end
		for (int i = 0; i < kf_count; i++) begin
			nx = (i + 1 == kf_count) ? 0 : i + 1;
			d = 64'(kf_dur[i]);
			e = slope[nx] - slope[i];
			cf_lin[i] = slope[i];
			cf_sq[i] = signed_scaled_quotient(e, cct_pkg::FRAC_BITS + 1, d);
			cf_cub[i] = -signed_scaled_quotient(e, 2 * cct_pkg::FRAC_BITS, d * d);
			seg_begin[i] = acc;
			acc += d;
		end
		period_len = acc;
		curve_built = 1'b1;
	endfunction

	// Advances the predictor by one accepted item and returns its response.
	function automatic servo_resp_t trajectory_step(servo_cmd_t c);
		servo_resp_t rsp;
		longint      t;
		longint      r;
		longint      h;
		longint      v;
		int          seg;
		bit [63:0]   u;
		rsp.value = '0;
		rsp.status = cct_pkg::ST_OK;
		if (c.op == cct_pkg::OP_LOAD) begin
			if (c.duration == 0) begin
				rsp.status = cct_pkg::ST_ZERO_DUR;
			end else begin
				if (curve_built) begin
					curve_built = 1'b0;
					kf_count = 0;
					period_len = 0;
				end
				if (kf_count >= cct_pkg::MAX_KEYFRAMES) begin
					rsp.status = cct_pkg::ST_FULL;
					kf_count = 0;
				end else begin
					kf_pos[kf_count] = longint'(c.position);
					kf_dur[kf_count] = c.duration;
					kf_count++;
					if (c.closes_set) build_trajectory();
				end
			end
		end else if (!curve_built || kf_count == 0 || period_len == 0) begin
			rsp.status = cct_pkg::ST_NOT_READY;
		end else begin
			t = longint'(c.qtime);
			r = t % longint'(period_len);
			if (r < 0) r += longint'(period_len);
			seg = kf_count - 1;
			for (int i = 0; i < kf_count; i++) begin
				if (64'(r) <= seg_begin[i] + 64'(kf_dur[i])) begin
					seg = i;
					break;
				end
			end
			u = 64'(r) - seg_begin[seg];
			if (u > 64'hFFFF_FFFF) u = 64'hFFFF_FFFF;
			h = cf_cub[seg];
			h = clip48(fx_mul(h, u) + cf_sq[seg]);
			h = clip48(fx_mul(h, u) + cf_lin[seg]);
			v = fx_mul(h, u) + kf_pos[seg];
			if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
			if (v < -64'sh8000_0000) v = -64'sh8000_0000;
			rsp.value = v[31:0];
		end
		return rsp;
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(14, 0);
	endfunction

	// Drives one item at the falling edge and holds it until accepted.
	task automatic send_cmd(servo_cmd_t c, bit typed, servo_resp_t typed_resp);
		servo_resp_t predicted;
		int          gap;
		gap = draw_gap();
		repeat (gap) @(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {c.qtime, c.duration, c.position};
		s_axis_tuser = c.op;
		s_axis_tlast = c.closes_set;
		do @(posedge clk); while (!s_axis_tready);
		predicted = trajectory_step(c);
		pending_resp.push_back(typed ? typed_resp : predicted);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic send_load(logic signed [31:0] p, logic [31:0] d, bit last);
		servo_cmd_t  c;
		servo_resp_t none;
		c = '{cct_pkg::OP_LOAD, p, d, last, $urandom()};
		none = '{'0, cct_pkg::ST_OK};
		send_cmd(c, 1'b0, none);
	endtask

	task automatic send_query(logic signed [31:0] t);
		servo_cmd_t  c;
		servo_resp_t none;
		c = '{cct_pkg::OP_EVAL, $urandom(), $urandom(), $urandom_range(1, 0), t};
		none = '{'0, cct_pkg::ST_OK};
		send_cmd(c, 1'b0, none);
	endtask

	// Result side: a random stall before each item, then compare with the oldest
	// pending expectation.
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		forever begin
			gap = draw_gap();
			m_axis_tready = 1'b0;
			repeat (gap) @(negedge clk);
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		servo_resp_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_resp.size() == 0) begin
				$error("unexpected result item value=%h status=%0d", m_axis_tdata, m_axis_tuser);
				failed = 1'b1;
			end else begin
				want = pending_resp.pop_front();
				if (m_axis_tdata !== want.value) begin
					$error("value expected %h actual %h", want.value, m_axis_tdata);
					failed = 1'b1;
				end
				if (m_axis_tuser !== want.status) begin
					$error("status expected %0d actual %0d", want.status, m_axis_tuser);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		directed_row_t directed[$];
		servo_resp_t   none;
		int            sent;
		int            nkeys;
		int            choice;
		logic [31:0]   d;
		logic [31:0]   t;
		bit [63:0]     span;

		failed = 1'b0;
		no_idle = 1'b0;
		kf_count = 0;
		period_len = 0;
		curve_built = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		none = '{'0, cct_pkg::ST_OK};

		// Query before any curve, zero-duration load, extreme keyframes, then queries
		// at the extremes of time and on segment boundaries.
		directed = '{
			'{'{cct_pkg::OP_EVAL, 32'sh0, 32'h0, 1'b0, 32'sh0}, 1'b1,
				'{32'h0, cct_pkg::ST_NOT_READY}},
			'{'{cct_pkg::OP_LOAD, 32'sh1234, 32'h0, 1'b1, 32'sh0}, 1'b1,
				'{32'h0, cct_pkg::ST_ZERO_DUR}},
			'{'{cct_pkg::OP_EVAL, 32'sh0, 32'h0, 1'b0, 32'sh10}, 1'b1,
				'{32'h0, cct_pkg::ST_NOT_READY}},
			'{'{cct_pkg::OP_LOAD, 32'sh7FFF_FFFF, 32'h1_0000, 1'b0, 32'sh0}, 1'b1,
				'{32'h0, cct_pkg::ST_OK}},
			'{'{cct_pkg::OP_LOAD, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b1, 32'sh0}, 1'b1,
				'{32'h0, cct_pkg::ST_OK}},
			'{'{cct_pkg::OP_EVAL, 32'sh0, 32'h0, 1'b0, 32'sh0}, 1'b1,
				'{32'h7FFF_FFFF, cct_pkg::ST_OK}},
			'{'{cct_pkg::OP_EVAL, 32'sh0, 32'h0, 1'b0, 32'sh1_0000}, 1'b0, none},
			'{'{cct_pkg::OP_EVAL, 32'sh0, 32'h0, 1'b0, 32'sh7FFF_FFFF}, 1'b0, none},
			'{'{cct_pkg::OP_EVAL, 32'sh0, 32'h0, 1'b0, 32'sh8000_0000}, 1'b0, none},
			'{'{cct_pkg::OP_EVAL, 32'sh0, 32'h0, 1'b0, 32'shFFFF_FFFF}, 1'b0, none},
			// A load after a finished curve starts a new set; a one-key curve is flat.
			'{'{cct_pkg::OP_LOAD, 32'sh5_0000, 32'h2_0000, 1'b1, 32'sh0}, 1'b1,
				'{32'h0, cct_pkg::ST_OK}},
			'{'{cct_pkg::OP_EVAL, 32'sh0, 32'h0, 1'b0, 32'sh8000_0000}, 1'b1,
				'{32'h5_0000, cct_pkg::ST_OK}},
			'{'{cct_pkg::OP_LOAD, 32'sh0, 32'h1_0000, 1'b0, 32'sh0}, 1'b1,
				'{32'h0, cct_pkg::ST_OK}},
			'{'{cct_pkg::OP_LOAD, 32'sh4_0000, 32'h3_0000, 1'b0, 32'sh0}, 1'b1,
				'{32'h0, cct_pkg::ST_OK}},
			'{'{cct_pkg::OP_LOAD, -32'sh2_0000, 32'h1, 1'b1, 32'sh0}, 1'b1,
				'{32'h0, cct_pkg::ST_OK}},
			'{'{cct_pkg::OP_EVAL, 32'sh0, 32'h0, 1'b0, 32'sh1_0000}, 1'b0, none},
			'{'{cct_pkg::OP_EVAL, 32'sh0, 32'h0, 1'b0, 32'sh4_0000}, 1'b0, none},
			'{'{cct_pkg::OP_EVAL, 32'sh0, 32'h0, 1'b0, 32'sh4_0001}, 1'b1,
				'{32'h0, cct_pkg::ST_OK}},
			'{'{cct_pkg::OP_EVAL, 32'sh0, 32'h0, 1'b0, 32'sh2_8000}, 1'b0, none},
			'{'{cct_pkg::OP_EVAL, 32'sh0, 32'h0, 1'b0, -32'sh8000}, 1'b0, none}
		};
		foreach (directed[i]) send_cmd(directed[i].cmd, directed[i].typed, directed[i].resp);

		// Sixteen loads without a closing mark fill the table; a seventeenth, closing load overflows it.
		for (int i = 0; i < cct_pkg::MAX_KEYFRAMES; i++)
			send_load($urandom(), $urandom_range(9, 1), 1'b0);
		send_cmd('{cct_pkg::OP_LOAD, 32'sh1, 32'h1, 1'b1, 32'sh0}, 1'b1,
			'{32'h0, cct_pkg::ST_FULL});
		send_query($urandom());
		sent = 20 + cct_pkg::MAX_KEYFRAMES + 2;

		// Random part: mostly complete keyframe sets followed by queries, with some
		// zero durations, overflowing sets and stray queries mixed in.
		while (sent < 1300) begin
			no_idle = ($urandom_range(9, 0) == 0);
			choice = $urandom_range(9, 0);
			if (choice < 7) begin
				nkeys = ($urandom_range(7, 0) == 0) ? $urandom_range(cct_pkg::MAX_KEYFRAMES, 1)
					: $urandom_range(4, 1);
				span = 0;
				for (int k = 0; k < nkeys; k++) begin
					if ($urandom_range(5, 0) == 0) d = $urandom() | 32'h1;
					else d = $urandom_range(32'h4_0000, 1);
					if ($urandom_range(11, 0) == 0) send_load($urandom(), 32'h0, 1'b0);
					if ($urandom_range(2, 0) == 0) send_load($urandom(), d, k == nkeys - 1);
					else send_load($signed($urandom_range(32'h20_0000, 0)) - 32'sh10_0000, d,
						k == nkeys - 1);
					span += d;
					sent++;
				end
				repeat ($urandom_range(12, 3)) begin
					if ($urandom_range(3, 0) == 0) t = $urandom();
					else if (span < 64'h7FFF_FFFF) t = $urandom_range(32'(span), 0);
					else t = $urandom() & 32'h7FFF_FFFF;
					send_query(t);
					sent++;
				end
			end else if (choice == 7) begin
				repeat (cct_pkg::MAX_KEYFRAMES + 1) begin
					send_load($urandom(), $urandom() | 32'h1, 1'b0);
					sent++;
				end
				send_query($urandom());
				sent++;
			end else begin
				if ($urandom_range(1, 0) == 0) send_load($urandom(), 32'h0, $urandom_range(1, 0));
				else send_query($urandom());
				sent++;
			end
		end
		no_idle = 1'b0;

		while (pending_resp.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (!failed && pending_resp.size() == 0) begin
			$display("cyclic_cubic_trajectory test passed");
		end else begin
			$display("cyclic_cubic_trajectory test failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/cct_pkg.sv
rtl/cct_div.sv
rtl/cct_mul.sv
rtl/cyclic_cubic_trajectory.sv
tb/sv/cyclic_cubic_trajectory_tb.sv
